[sv/snp_pkg.sv]
// Shared types and constants for the 2x3 spectral-norm shrink block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package snp_pkg;

	// element and register widths
	localparam int XW = 32;        // Q15.16 element
	localparam int TW = 31;        // unsigned threshold and top singular value
	localparam int WW = 64;        // wide word: Gram terms, trace, root of discriminant
	localparam int SW = 33;        // singular value width
	localparam int QW = 31;        // quotient bits of a Q30 ratio in [0, 1]
	localparam int FRAC_P = 30;    // fraction bits of the ratios
	localparam int NDIV = 5;       // ratios formed side by side

	typedef struct packed {
		logic signed [XW-1:0] q_r0c0;
		logic signed [XW-1:0] q_r0c1;
		logic signed [XW-1:0] q_r0c2;
		logic signed [XW-1:0] q_r1c0;
		logic signed [XW-1:0] q_r1c1;
		logic signed [XW-1:0] q_r1c2;
	} blk_t;

	typedef struct packed {
		logic signed [XW-1:0] m_r0c0;
		logic signed [XW-1:0] m_r0c1;
		logic signed [XW-1:0] m_r0c2;
		logic signed [XW-1:0] m_r1c0;
		logic signed [XW-1:0] m_r1c1;
		logic signed [XW-1:0] m_r1c2;
		logic [TW-1:0]        top_singular;
		logic                 degenerate;
	} res_t;

endpackage

`default_nettype wire

[sv/snp_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per register stage, several lanes.
// Depends on snp_pkg for the default root width; carries a sideband alongside.
`default_nettype none

module snp_sqrt_pipe #(
	parameter int LANES  = 1,
	parameter int RW     = snp_pkg::WW,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid,
	input  logic [LANES-1:0][2*RW-1:0]  rad,
	input  logic [SIDE_W-1:0]           side,
	output logic                        root_valid,
	output logic [LANES-1:0][RW-1:0]    root,
	output logic [SIDE_W-1:0]           root_side
);
	import snp_pkg::*;

	localparam int W = RW + 3;

	logic                        v_s    [RW];
	logic [LANES-1:0][W-1:0]     rem_s  [RW];
	logic [LANES-1:0][RW-1:0]    root_s [RW];
	logic [LANES-1:0][2*RW-1:0]  rad_s  [RW];
	logic [SIDE_W-1:0]           side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic                        pv;
		logic [LANES-1:0][W-1:0]     prem;
		logic [LANES-1:0][RW-1:0]    proot;
		logic [LANES-1:0][2*RW-1:0]  prad;
		logic [SIDE_W-1:0]           pside;
		logic [LANES-1:0][W-1:0]     nrem;
		logic [LANES-1:0][RW-1:0]    nroot;
		logic [LANES-1:0][2*RW-1:0]  nrad;

		// pick up the previous stage, or the inputs at the head
		if (k == 0) begin : g_head
			assign pv    = valid;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad;
			assign pside = side;
		end else begin : g_body
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign prad  = rad_s[k-1];
			assign pside = side_s[k-1];
		end

		// bring down two radicand bits and try the next root bit
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [W-1:0] cat;
			logic [W-1:0] trial;
			logic         ge;

			assign cat      = {prem[l][W-3:0], prad[l][2*RW-1 -: 2]};
			assign trial    = {1'b0, proot[l], 2'b01};
			assign ge       = cat >= trial;
			assign nrem[l]  = ge ? cat - trial : cat;
			assign nroot[l] = {proot[l][RW-2:0], ge};
			assign nrad[l]  = {prad[l][2*RW-3:0], 2'b00};
		end

		// advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// advance the payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= nrem;
				root_s[k] <= nroot;
				rad_s[k]  <= nrad;
				side_s[k] <= pside;
			end
		end
	end

	assign root_valid = v_s[RW-1];
	assign root       = root_s[RW-1];
	assign root_side  = side_s[RW-1];

endmodule

`default_nettype wire

[sv/snp_div_pipe.sv]
// Pipelined restoring divider for Q30 ratios num/den with num <= den,
// one quotient bit per register stage, several lanes. Depends on snp_pkg.
`default_nettype none

module snp_div_pipe #(
	parameter int LANES  = snp_pkg::NDIV,
	parameter int DW     = snp_pkg::WW,
	parameter int QW     = snp_pkg::QW,
	parameter int SIDE_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid,
	input  logic [LANES-1:0][DW-1:0]  num,
	input  logic [LANES-1:0][DW-1:0]  den,
	input  logic [SIDE_W-1:0]         side,
	output logic                      quo_valid,
	output logic [LANES-1:0][QW-1:0]  quo,
	output logic [SIDE_W-1:0]         quo_side
);
	import snp_pkg::*;

	logic                      v_s    [QW];
	logic [LANES-1:0][DW-1:0]  rem_s  [QW];
	logic [LANES-1:0][QW-1:0]  quo_s  [QW];
	logic [LANES-1:0][DW-1:0]  den_s  [QW];
	logic [SIDE_W-1:0]         side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                      pv;
		logic [LANES-1:0][DW-1:0]  prem;
		logic [LANES-1:0]          pnb;
		logic [LANES-1:0][QW-1:0]  pquo;
		logic [LANES-1:0][DW-1:0]  pden;
		logic [SIDE_W-1:0]         pside;
		logic [LANES-1:0][DW-1:0]  nrem;
		logic [LANES-1:0][QW-1:0]  nquo;

		// the dividend is num shifted up by the fraction width: its upper
		// part seeds the remainder, the lowest bit of num comes in first
		if (k == 0) begin : g_head
			assign pv    = valid;
			assign pquo  = '0;
			assign pden  = den;
			assign pside = side;
			for (genvar l = 0; l < LANES; l++) begin : g_seed
				assign prem[l] = {1'b0, num[l][DW-1:1]};
				assign pnb[l]  = num[l][0];
			end
		end else begin : g_body
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign pnb   = '0;
			assign pquo  = quo_s[k-1];
			assign pden  = den_s[k-1];
			assign pside = side_s[k-1];
		end

		// shift in one dividend bit and subtract where it fits
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] cat;
			logic [DW:0] dx;
			logic [DW:0] dif;
			logic        ge;

			assign cat     = {prem[l], pnb[l]};
			assign dx      = {1'b0, pden[l]};
			assign dif     = cat - dx;
			assign ge      = cat >= dx;
			assign nrem[l] = ge ? dif[DW-1:0] : cat[DW-1:0];
			assign nquo[l] = {pquo[l][QW-2:0], ge};
		end

		// advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// advance the payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= nrem;
				quo_s[k]  <= nquo;
				den_s[k]  <= pden;
				side_s[k] <= pside;
			end
		end
	end

	assign quo_valid = v_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign quo_side  = side_s[QW-1];

endmodule

`default_nettype wire

[sv/spectral_norm_prox_2x3_core.sv]
// Spectral-norm proximal step on one 2x3 Q15.16 block: shrinks the singular
// values and returns the rebuilt block. Depends on snp_pkg, snp_sqrt_pipe, snp_div_pipe.
//
// Use:
//   Input channel blk_valid / blk_stall / blk carries one block per transfer;
//   output channel res_valid / res_stall / res returns one result per block,
//   in order. A transfer happens at a clock edge with valid high, stall low.
//   cfg_wen / cfg_wdata load the shrink threshold; write it only while idle.
// Throughput and pipeline:
//   One block is taken every cycle while blk_stall is low. The pipeline is
//   made of the bit-per-stage square roots (64 stages for the eigenvalue
//   spread, 33 for the singular values) and the 31-stage ratio divider,
//   plus 14 arithmetic stages and the output register.
// Reset:
//   arst_n clears all valid bits and the threshold to zero; no clearing pass.
// Stall:
//   The output register holds its result while res_stall is high; one more
//   result is caught in a skid register, then blk_stall rises and the whole
//   pipeline holds until the skid register drains.
`default_nettype none

module spectral_norm_prox_2x3_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [snp_pkg::TW-1:0] cfg_wdata,
	input  logic                 blk_valid,
	output logic                 blk_stall,
	input  snp_pkg::blk_t        blk,
	output logic                 res_valid,
	input  logic                 res_stall,
	output snp_pkg::res_t        res
);
	import snp_pkg::*;

	typedef struct packed {
		blk_t          x;
		logic [WW-1:0] a;
		logic [WW-1:0] d;
		logic [WW-1:0] tr;
		logic [WW-1:0] bm;
		logic          bneg;
		logic          bzero;
	} hside_t;

	typedef struct packed {
		blk_t          x;
		logic [WW-1:0] e0;
		logic [WW-1:0] e1;
		logic [WW-1:0] h;
		logic [WW-1:0] bm;
		logic          bneg;
		logic          bzero;
	} sside_t;

	typedef struct packed {
		blk_t          x;
		logic [SW-1:0] n1;
		logic          bneg;
		logic          deg;
	} dside_t;

	logic en;
	logic [TW-1:0] thr_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	// stage 1: squares and cross products of the elements
	logic signed [WW-1:0] xe [6];
	logic                 v_s1;
	blk_t                 x_s1;
	logic [WW-1:0]        sq_s1 [6];
	logic signed [WW-1:0] cr_s1 [3];

	assign xe[0] = WW'(blk.q_r0c0);
	assign xe[1] = WW'(blk.q_r0c1);
	assign xe[2] = WW'(blk.q_r0c2);
	assign xe[3] = WW'(blk.q_r1c0);
	assign xe[4] = WW'(blk.q_r1c1);
	assign xe[5] = WW'(blk.q_r1c2);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= blk;
			for (int i = 0; i < 6; i++) begin
				sq_s1[i] <= xe[i] * xe[i];
			end
			for (int j = 0; j < 3; j++) begin
				cr_s1[j] <= xe[j] * xe[3+j];
			end
		end
	end

	// stage 2: Gram matrix entries a, d, b
	logic                 v_s2;
	blk_t                 x_s2;
	logic [WW-1:0]        a_s2, d_s2;
	logic signed [WW-1:0] b_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_s1;
			a_s2 <= (sq_s1[0] + sq_s1[1] + sq_s1[2]) >> 2;
			d_s2 <= (sq_s1[3] + sq_s1[4] + sq_s1[5]) >> 2;
			b_s2 <= (cr_s1[0] >>> 2) + (cr_s1[1] >>> 2) + (cr_s1[2] >>> 2);
		end
	end

	// stage 3: trace, spread and magnitude of b
	logic   v_s3;
	hside_t hs_s3;
	logic [WW-1:0] amd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s3.x     <= x_s2;
			hs_s3.a     <= a_s2;
			hs_s3.d     <= d_s2;
			hs_s3.tr    <= a_s2 + d_s2;
			hs_s3.bm    <= b_s2[WW-1] ? WW'(-b_s2) : WW'(b_s2);
			hs_s3.bneg  <= b_s2[WW-1];
			hs_s3.bzero <= b_s2 == '0;
			amd_s3      <= (a_s2 >= d_s2) ? a_s2 - d_s2 : d_s2 - a_s2;
		end
	end

	// stage 4: partial products of (a-d)^2 and (2b)^2, split at bit 31
	logic          v_s4;
	hside_t        hs_s4;
	logic [WW-1:0] u3;
	logic [WW-1:0] ahh_s4, ahl_s4, all_s4, uhh_s4, uhl_s4, ull_s4;

	assign u3 = {hs_s3.bm[WW-2:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s4  <= hs_s3;
			ahh_s4 <= WW'(amd_s3[62:31]) * WW'(amd_s3[62:31]);
			ahl_s4 <= WW'(amd_s3[62:31]) * WW'(amd_s3[30:0]);
			all_s4 <= WW'(amd_s3[30:0]) * WW'(amd_s3[30:0]);
			uhh_s4 <= WW'(u3[62:31]) * WW'(u3[62:31]);
			uhl_s4 <= WW'(u3[62:31]) * WW'(u3[30:0]);
			ull_s4 <= WW'(u3[30:0]) * WW'(u3[30:0]);
		end
	end

	// stage 5: assemble both squares
	logic            v_s5;
	hside_t          hs_s5;
	logic [2*WW-1:0] sqa_s5, sqb_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s5  <= hs_s4;
			sqa_s5 <= ({{WW{1'b0}}, ahh_s4} << 62) + ({{WW{1'b0}}, ahl_s4} << 32)
				+ {{WW{1'b0}}, all_s4};
			sqb_s5 <= ({{WW{1'b0}}, uhh_s4} << 62) + ({{WW{1'b0}}, uhl_s4} << 32)
				+ {{WW{1'b0}}, ull_s4};
		end
	end

	// stage 6: discriminant
	logic            v_s6;
	hside_t          hs_s6;
	logic [2*WW-1:0] disc_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s6   <= hs_s5;
			disc_s6 <= sqa_s5 + sqb_s5;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= blk_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// eigenvalue spread h = floor(sqrt(disc))
	logic              h_valid;
	logic [0:0][WW-1:0] h_root;
	hside_t            h_side;

	snp_sqrt_pipe #(
		.LANES  (1),
		.RW     (WW),
		.SIDE_W ($bits(hside_t))
	) u_sqrt_h (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (v_s6),
		.rad        (disc_s6),
		.side       (hs_s6),
		.root_valid (h_valid),
		.root       (h_root),
		.root_side  (h_side)
	);

	// stage 7: eigenvalues
	logic          v_s7;
	hside_t        hs_s7;
	logic [WW-1:0] h_s7, lam1_s7, lam2_s7;
	logic [WW:0]   tph;

	assign tph = {1'b0, h_side.tr} + {1'b0, h_root[0]};

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s7   <= h_side;
			h_s7    <= h_root[0];
			lam1_s7 <= tph[WW:1];
			lam2_s7 <= (h_side.tr > h_root[0]) ? (h_side.tr - h_root[0]) >> 1 : '0;
		end
	end

	// stage 8: projector numerators and singular value radicands
	logic                    v_s8;
	sside_t                  ss_s8;
	logic [1:0][2*SW-1:0]    rad_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s8.x     <= hs_s7.x;
			ss_s8.e0    <= (hs_s7.a > lam2_s7) ? hs_s7.a - lam2_s7 : '0;
			ss_s8.e1    <= (hs_s7.d > lam2_s7) ? hs_s7.d - lam2_s7 : '0;
			ss_s8.h     <= h_s7;
			ss_s8.bm    <= hs_s7.bm;
			ss_s8.bneg  <= hs_s7.bneg;
			ss_s8.bzero <= hs_s7.bzero;
			rad_s8[0]   <= {lam1_s7, 2'b00};
			rad_s8[1]   <= {lam2_s7, 2'b00};
		end
	end

	// singular values s1, s2
	logic               s_valid;
	logic [1:0][SW-1:0] s_root;
	sside_t             s_side;

	snp_sqrt_pipe #(
		.LANES  (2),
		.RW     (SW),
		.SIDE_W ($bits(sside_t))
	) u_sqrt_s (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (v_s8),
		.rad        (rad_s8),
		.side       (ss_s8),
		.root_valid (s_valid),
		.root       (s_root),
		.root_side  (s_side)
	);

	// stage 9: sum and gap of the singular values, flag for a zero b or a zero divisor s2
	logic          v_s9;
	sside_t        ss_s9;
	logic [SW-1:0] s1_s9, s2_s9, dif_s9;
	logic [SW:0]   sum_s9;
	logic          deg_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s9  <= s_side;
			s1_s9  <= s_root[0];
			s2_s9  <= s_root[1];
			sum_s9 <= {1'b0, s_root[0]} + {1'b0, s_root[1]};
			dif_s9 <= s_root[0] - s_root[1];
			deg_s9 <= s_side.bzero || (s_root[1] == '0);
		end
	end

	// stage 10: shrink against the threshold, set up the ratio divisions
	logic                   v_s10;
	logic [NDIV-1:0][WW-1:0] num_s10, den_s10;
	dside_t                 ds_s10;
	logic [SW:0]            t_ext;
	logic [SW:0]            avg_full;
	logic [SW-1:0]          n1_c, n2_c;

	assign t_ext    = (SW+1)'(thr_q);
	assign avg_full = (sum_s9 - t_ext) >> 1;

	always_comb begin
		if (sum_s9 <= t_ext) begin
			n1_c = '0;
			n2_c = '0;
		end else if ({1'b0, dif_s9} <= t_ext) begin
			n1_c = avg_full[SW-1:0];
			n2_c = avg_full[SW-1:0];
		end else begin
			n1_c = s1_s9 - t_ext[SW-1:0];
			n2_c = s2_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s10[0]  <= WW'(n1_c);
			num_s10[1]  <= WW'(n2_c);
			num_s10[2]  <= ss_s9.e0;
			num_s10[3]  <= ss_s9.e1;
			num_s10[4]  <= ss_s9.bm;
			den_s10[0]  <= WW'(s1_s9);
			den_s10[1]  <= WW'(s2_s9);
			den_s10[2]  <= ss_s9.h;
			den_s10[3]  <= ss_s9.h;
			den_s10[4]  <= ss_s9.h;
			ds_s10.x    <= ss_s9.x;
			ds_s10.n1   <= n1_c;
			ds_s10.bneg <= ss_s9.bneg;
			ds_s10.deg  <= deg_s9;
		end
	end

	// ratios r1, r2, p00, p11, |p01|
	logic                    q_valid;
	logic [NDIV-1:0][QW-1:0] q_quo;
	dside_t                  q_side;

	snp_div_pipe #(
		.LANES  (NDIV),
		.DW     (WW),
		.QW     (QW),
		.SIDE_W ($bits(dside_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (v_s10),
		.num       (num_s10),
		.den       (den_s10),
		.side      (ds_s10),
		.quo_valid (q_valid),
		.quo       (q_quo),
		.quo_side  (q_side)
	);

	// stage 11: ratio difference and signed off-diagonal ratio
	logic                 v_s11;
	dside_t               ds_s11;
	logic signed [XW-1:0] dr_s11, r2_s11, p00_s11, p11_s11, p01_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s11  <= q_side;
			dr_s11  <= $signed({1'b0, q_quo[0]}) - $signed({1'b0, q_quo[1]});
			r2_s11  <= $signed({1'b0, q_quo[1]});
			p00_s11 <= $signed({1'b0, q_quo[2]});
			p11_s11 <= $signed({1'b0, q_quo[3]});
			p01_s11 <= q_side.bneg ? -$signed({1'b0, q_quo[4]}) : $signed({1'b0, q_quo[4]});
		end
	end

	// stage 12: scale the projector by the ratio difference
	logic                 v_s12;
	dside_t               ds_s12;
	logic signed [XW-1:0] r2_s12;
	logic signed [WW-1:0] m00_s12, m11_s12, m01_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s12  <= ds_s11;
			r2_s12  <= r2_s11;
			m00_s12 <= WW'(dr_s11) * WW'(p00_s11);
			m11_s12 <= WW'(dr_s11) * WW'(p11_s11);
			m01_s12 <= WW'(dr_s11) * WW'(p01_s11);
		end
	end

	// stage 13: entries of the shrink matrix P
	logic                 v_s13;
	dside_t               ds_s13;
	logic signed [XW-1:0] pm00_s13, pm11_s13, pm01_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s13   <= ds_s12;
			pm00_s13 <= r2_s12 + XW'(m00_s12 >>> FRAC_P);
			pm11_s13 <= r2_s12 + XW'(m11_s12 >>> FRAC_P);
			pm01_s13 <= XW'(m01_s12 >>> FRAC_P);
		end
	end

	// stage 14: products of P with the block rows
	logic                 v_s14;
	dside_t               ds_s14;
	logic signed [WW-1:0] c0e [3];
	logic signed [WW-1:0] c1e [3];
	logic signed [WW-1:0] pa_s14 [3];
	logic signed [WW-1:0] pb_s14 [3];
	logic signed [WW-1:0] pc_s14 [3];
	logic signed [WW-1:0] pd_s14 [3];

	assign c0e[0] = WW'(ds_s13.x.q_r0c0);
	assign c0e[1] = WW'(ds_s13.x.q_r0c1);
	assign c0e[2] = WW'(ds_s13.x.q_r0c2);
	assign c1e[0] = WW'(ds_s13.x.q_r1c0);
	assign c1e[1] = WW'(ds_s13.x.q_r1c1);
	assign c1e[2] = WW'(ds_s13.x.q_r1c2);

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s14 <= ds_s13;
			for (int j = 0; j < 3; j++) begin
				pa_s14[j] <= WW'(pm00_s13) * c0e[j];
				pb_s14[j] <= WW'(pm01_s13) * c1e[j];
				pc_s14[j] <= WW'(pm01_s13) * c0e[j];
				pd_s14[j] <= WW'(pm11_s13) * c1e[j];
			end
		end
	end

	// valid bits of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s7  <= h_valid;
			v_s8  <= v_s7;
			v_s9  <= s_valid;
			v_s10 <= v_s9;
			v_s11 <= q_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// round down, saturate and zero out degenerate blocks
	function automatic logic signed [XW-1:0] sat_elem(logic signed [WW-1:0] pl,
			logic signed [WW-1:0] pr);
		logic signed [WW:0] acc;
		logic signed [WW:0] sh;
		acc = (WW+1)'(pl) + (WW+1)'(pr);
		sh  = acc >>> FRAC_P;
		if (sh > $signed((WW+1)'(33'h07FFFFFFF))) begin
			return {1'b0, {(XW-1){1'b1}}};
		end else if (sh < -$signed((WW+1)'(33'h080000000))) begin
			return {1'b1, {(XW-1){1'b0}}};
		end else begin
			return sh[XW-1:0];
		end
	endfunction

	res_t res_d;

	always_comb begin
		res_d = '0;
		if (ds_s14.deg) begin
			res_d.degenerate = 1'b1;
		end else begin
			res_d.m_r0c0       = sat_elem(pa_s14[0], pb_s14[0]);
			res_d.m_r0c1       = sat_elem(pa_s14[1], pb_s14[1]);
			res_d.m_r0c2       = sat_elem(pa_s14[2], pb_s14[2]);
			res_d.m_r1c0       = sat_elem(pc_s14[0], pd_s14[0]);
			res_d.m_r1c1       = sat_elem(pc_s14[1], pd_s14[1]);
			res_d.m_r1c2       = sat_elem(pc_s14[2], pd_s14[2]);
			res_d.top_singular = (|ds_s14.n1[SW-1:TW]) ? '1 : ds_s14.n1[TW-1:0];
		end
	end

	// output register plus one skid entry; freeze the pipe while skid holds data
	logic res_v_q, skid_v_q;
	res_t res_q, skid_q;
	logic push, pop;

	assign en        = !skid_v_q;
	assign blk_stall = skid_v_q;
	assign push      = en && v_s14;
	assign pop       = res_v_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!res_v_q || pop) begin
			if (skid_v_q) begin
				res_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				res_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_v_q || pop) begin
			res_q <= skid_v_q ? skid_q : res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[dv/tb_spectral_norm_prox_2x3_core.sv]
// Testbench for spectral_norm_prox_2x3_core: random and directed 2x3 blocks,
// checked against an in-bench fixed-point model. Depends on snp_pkg and the core.
`timescale 1ns / 100ps

module tb_spectral_norm_prox_2x3_core;
	import snp_pkg::*;

	localparam int LATENCY  = 143;
	localparam int WD_LIMIT = 3000;
	localparam int HOLD_LEN = 400;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// expected-result store with its own copy of the shrink threshold
	class shrink_scoreboard;
		logic [TW-1:0] thresh;
		res_t expected_q[$];
		int mismatches;

		function new();
			thresh = '0;
			mismatches = 0;
		endfunction

		static function logic [63:0] root128(logic [127:0] n);
			logic [63:0] r;
			logic [63:0] c;
			logic [127:0] cc;
			r = '0;
			for (int i = 63; i >= 0; i--) begin
				c = r | (64'd1 << i);
				cc = {64'd0, c} * {64'd0, c};
				if (cc <= n)
					r = c;
			end
			return r;
		endfunction

		// Q30 ratio num/den, clamped to one; a zero divisor also clamps
		static function logic signed [63:0] ratio_q30(logic [63:0] num, logic [63:0] den);
			logic [127:0] q;
			if (den == 0)
				return ONE_Q30;
			q = ({64'd0, num} << 30) / {64'd0, den};
			return (q > {64'd0, ONE_Q30}) ? ONE_Q30 : q[63:0];
		endfunction

		static function logic signed [31:0] sat_elem(logic signed [63:0] v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function res_t shrink_block(blk_t q);
			logic signed [63:0] x[6];
			logic [63:0] a, d, tr, amd, bm, h, lam1, lam2, s1, s2, n1, n2, e0, e1, t;
			logic signed [63:0] b, r1, r2, dr, p00, p01, p11, pp00, pp01, pp11;
			logic [127:0] disc;
			res_t r;
			x[0] = q.q_r0c0; x[1] = q.q_r0c1; x[2] = q.q_r0c2;
			x[3] = q.q_r1c0; x[4] = q.q_r1c1; x[5] = q.q_r1c2;
			r = '0;
			// Gram matrix terms in Q30
			a = (x[0] * x[0] + x[1] * x[1] + x[2] * x[2]) >> 2;
			d = (x[3] * x[3] + x[4] * x[4] + x[5] * x[5]) >> 2;
			b = ((x[0] * x[3]) >>> 2) + ((x[1] * x[4]) >>> 2) + ((x[2] * x[5]) >>> 2);
			tr = a + d;
			amd = (a >= d) ? a - d : d - a;
			bm = (b < 0) ? -b : b;
			disc = {64'd0, amd} * {64'd0, amd} + {64'd0, 2 * bm} * {64'd0, 2 * bm};
			h = root128(disc);
			lam1 = (tr + h) >> 1;
			lam2 = (tr > h) ? (tr - h) >> 1 : 64'd0;
			s1 = root128({64'd0, lam1} << 2);
			s2 = root128({64'd0, lam2} << 2);
			if (b == 0 || s2 == 0) begin
				r.degenerate = 1'b1;
				return r;
			end
			// shrink the singular values
			t = {33'd0, thresh};
			if (s1 + s2 <= t) begin
				n1 = 0;
				n2 = 0;
			end else if (s1 - s2 <= t) begin
				n1 = (s1 + s2 - t) >> 1;
				n2 = n1;
			end else begin
				n1 = s1 - t;
				n2 = s2;
			end
			r1 = ratio_q30(n1, s1);
			r2 = ratio_q30(n2, s2);
			dr = r1 - r2;
			e0 = (a > lam2) ? a - lam2 : 64'd0;
			e1 = (d > lam2) ? d - lam2 : 64'd0;
			p00 = ratio_q30(e0, h);
			p11 = ratio_q30(e1, h);
			p01 = ratio_q30(bm, h);
			if (b < 0)
				p01 = -p01;
			pp00 = r2 + ((dr * p00) >>> 30);
			pp11 = r2 + ((dr * p11) >>> 30);
			pp01 = (dr * p01) >>> 30;
			r.m_r0c0 = sat_elem((pp00 * x[0] + pp01 * x[3]) >>> 30);
			r.m_r0c1 = sat_elem((pp00 * x[1] + pp01 * x[4]) >>> 30);
			r.m_r0c2 = sat_elem((pp00 * x[2] + pp01 * x[5]) >>> 30);
			r.m_r1c0 = sat_elem((pp01 * x[0] + pp11 * x[3]) >>> 30);
			r.m_r1c1 = sat_elem((pp01 * x[1] + pp11 * x[4]) >>> 30);
			r.m_r1c2 = sat_elem((pp01 * x[2] + pp11 * x[5]) >>> 30);
			r.top_singular = (n1 > 64'h7fffffff) ? 31'h7fffffff : n1[30:0];
			r.degenerate = 1'b0;
			return r;
		endfunction

		function void note_block(blk_t q);
			expected_q.push_back(shrink_block(q));
		endfunction

		function void check_result(res_t got);
			res_t w;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with none expected: %p", got);
				return;
			end
			w = expected_q.pop_front();
			if (got.m_r0c0 !== w.m_r0c0 || got.m_r0c1 !== w.m_r0c1 ||
			    got.m_r0c2 !== w.m_r0c2 || got.m_r1c0 !== w.m_r1c0 ||
			    got.m_r1c1 !== w.m_r1c1 || got.m_r1c2 !== w.m_r1c2 ||
			    got.top_singular !== w.top_singular || got.degenerate !== w.degenerate) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: mismatch at %0t", $realtime);
					$display("  expected %p", w);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [TW-1:0] cfg_wdata = '0;
	logic blk_valid = 1'b0;
	logic blk_stall;
	blk_t blk = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	shrink_scoreboard sb = new();
	int blocks_in = 0, results_out = 0, idle_cycles = 0;
	int settings_run = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	always #10 clk = ~clk;

	spectral_norm_prox_2x3_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.blk_valid(blk_valid), .blk_stall(blk_stall), .blk(blk),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// note every transfer on both channels; watch for a hang
	always @(posedge clk) begin
		if (blk_valid && !blk_stall) begin
			sb.note_block(blk);
			blocks_in++;
		end
		if (res_valid && !res_stall) begin
			sb.check_result(res);
			results_out++;
		end
		if ((blk_valid && !blk_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WD_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall per result, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	task automatic send_block(blk_t v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			blk_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_valid <= 1'b1;
		blk <= v;
		do @(posedge clk); while (blk_stall);
	endtask

	// drain the pipe, then load a new threshold; the caller has dropped valid
	task automatic load_threshold(logic [TW-1:0] v);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.thresh = v;
		settings_run++;
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return 32'h80000000 | ($urandom() & 32'h3);
			2: return 32'h7fffffff - ($urandom() & 32'h3);
			default: return $signed($urandom()) >>> $urandom_range(6, 24);
		endcase
	endfunction

	function automatic blk_t rand_block();
		blk_t v;
		v.q_r0c0 = rand_elem(); v.q_r0c1 = rand_elem(); v.q_r0c2 = rand_elem();
		v.q_r1c0 = rand_elem(); v.q_r1c1 = rand_elem(); v.q_r1c2 = rand_elem();
		case ($urandom_range(0, 9))
			// rank one: second row copies the first
			0: begin
				v.q_r1c0 = v.q_r0c0; v.q_r1c1 = v.q_r0c1; v.q_r1c2 = v.q_r0c2;
			end
			// orthogonal rows give a zero cross term
			1: begin
				v.q_r0c2 = 0; v.q_r1c0 = 0; v.q_r1c1 = 0;
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic run_directed();
		blk_t v;
		v = '0;
		send_block(v);
		v = {6{32'h7fffffff}};
		send_block(v);
		v = {6{32'h80000000}};
		send_block(v);
		v = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
		send_block(v);
		v = {32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h1};
		send_block(v);
		v = {32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0};
		send_block(v);
		v = {32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 32'h00020000, 32'h00030000};
		send_block(v);
		v = {32'h00030000, 32'h00010000, 32'h0, 32'h00010000, 32'h00020000, 32'hffff0000};
		send_block(v);
		v = {32'h00020000, 32'h00001000, 32'h0, 32'hffff8000, 32'h00010000, 32'h00000400};
		send_block(v);
		v = {32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'h0};
		send_block(v);
		v = {32'h40000000, 32'h40000000, 32'hc0000000, 32'h40000000, 32'hc0000000, 32'h3fffffff};
		send_block(v);
		v = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7ffffffe, 32'h0};
		send_block(v);
		v = {32'h00050000, 32'hfffb0000, 32'h00020000, 32'h00050001, 32'hfffb0000, 32'h00020000};
		send_block(v);
		blk_valid <= 1'b0;
	endtask

	initial begin
		logic [TW-1:0] thresholds[5];
		thresholds[0] = 31'h7fffffff;
		thresholds[1] = 31'h00010000;
		thresholds[2] = TW'($urandom());
		thresholds[3] = TW'($urandom_range(1, 255));
		thresholds[4] = 31'd0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at the reset threshold and at the largest one
		run_directed();
		load_threshold(31'h7fffffff);
		run_directed();

		for (int ph = 0; ph < 5; ph++) begin
			load_threshold(thresholds[ph]);
			no_idle = (ph == 1);
			for (int k = 0; k < 290; k++) begin
				if (ph == 2 && k == 40)
					hold_req = 1'b1;
				if (ph == 3 && k == 100)
					no_idle = 1'b1;
				if (ph == 3 && k == 180)
					no_idle = 1'b0;
				send_block(rand_block());
			end
			blk_valid <= 1'b0;
		end
		no_idle = 1'b0;

		// wait out the last results
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Ran %0d blocks through %0d threshold settings, %0d results checked.",
		         blocks_in, settings_run + 1, results_out);
		$display("Covered corner values, rank-one and orthogonal rows, stalls and a long hold-off.");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding",
			         sb.mismatches, sb.expected_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
